@@ hdl/blb_pkg.sv @@
`timescale 1ns / 1ps

package blb_pkg;

	// server id space, fixed by the 4-bit server fields of a result item
	localparam int MAX_SERVERS = 16;

	// input command codes
	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_INIT   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_NO_SPARE    = 2'd1;
	localparam logic [1:0] ST_LAST_SERVER = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_BUCKET_COUNT   = 2'd0;
	localparam logic [1:0] REG_TOTAL_SERVERS  = 2'd1;
	localparam logic [1:0] REG_INITIAL_ACTIVE = 2'd2;

	// configuration reset values
	localparam logic [12:0] BC_RESET = 13'd3200;
	localparam logic [4:0]  TS_RESET = 5'd16;
	localparam logic [4:0]  IA_RESET = 5'd0;

	// datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_DIV_MOD,
		OP_DIV_FAC,
		OP_LK_READ,
		OP_LK_FIN,
		OP_INIT_SET,
		OP_INIT_DIRECT,
		OP_INIT_LEFT,
		OP_SCAN_START,
		OP_ADD_POP,
		OP_REM_POP,
		OP_BK_START,
		OP_BK_NEXT,
		OP_REB_SCAN,
		OP_REB_MOVE,
		OP_M_RD,
		OP_REM_MOVE,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] status;
	} cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       out_free;
		logic       div_done;
		logic       scan_done;
		logic       bk_end;
		logic       init_direct;
		logic       add_ok;
		logic       rem_ok;
		logic       reb_go;
		logic       reb_done;
		logic       found;
		logic       match;
	} stat_t;

endpackage

@@ hdl/blb_div.sv @@
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module blb_div #(
	parameter int DVW = 13
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [31:0]    dividend,
	input  logic [DVW-1:0] divisor,
	output logic           done,
	output logic [31:0]    quot,
	output logic [DVW-1:0] rem
);

	logic [DVW:0]   r_q;
	logic [31:0]    q_q;
	logic [DVW-1:0] d_q;
	logic [5:0]     cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DVW:0]   shifted;
	logic           ge;
	logic [DVW:0]   diff;

	// one trial subtraction
	always_comb begin
		shifted = {r_q[DVW-1:0], q_q[31]};
		ge      = shifted >= {1'b0, d_q};
		diff    = shifted - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			q_q <= dividend;
			d_q <= divisor;
		end else if (busy_q) begin
			r_q <= ge ? diff : shifted;
			q_q <= {q_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q[DVW-1:0];

endmodule

@@ hdl/blb_dp.sv @@
`timescale 1ns / 1ps

module blb_dp #(
	parameter int MAX_BUCKETS = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  blb_pkg::cmd_t       cmd,
	output blb_pkg::stat_t      stat,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_addr,
	input  logic [12:0]         cfg_wdata,
	input  logic [63:0]         s_axis_tdata,
	input  logic [1:0]          s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [47:0]         m_axis_tdata
);

	localparam int MAX_SERVERS = blb_pkg::MAX_SERVERS;
	localparam int BW  = $clog2(MAX_BUCKETS);
	localparam int CW  = $clog2(MAX_BUCKETS + 1);
	localparam int SW  = $clog2(MAX_SERVERS);
	localparam int SCW = $clog2(MAX_SERVERS + 1);
	localparam int LW  = $clog2(2 * MAX_BUCKETS);
	localparam int DVW = (CW > SCW) ? CW : SCW;
	localparam int MW  = SW + 1 + SW + 32;
	localparam logic [LW-1:0] LOAD_LIM = LW'(2 * MAX_BUCKETS - 1);

	// configuration registers
	logic [12:0] bc_q;
	logic [4:0]  ts_q;
	logic [4:0]  ia_q;

	// captured item
	logic [1:0]  cmd_q;
	logic [31:0] hash_q;
	logic [31:0] now_q;

	// server state
	logic [LW-1:0] load_q [MAX_SERVERS];
	logic          act_q  [MAX_SERVERS];
	logic [SW-1:0] actq_q [MAX_SERVERS];
	logic [SW-1:0] spq_q  [MAX_SERVERS];
	logic [SW-1:0] ahead_q, shead_q;
	logic [SCW-1:0] acnt_q, scnt_q;

	// walk state
	logic [CW-1:0]  fac_q;
	logic [SCW-1:0] grp_q;
	logic [CW-1:0]  within_q;
	logic [CW-1:0]  bk_q;
	logic [BW-1:0]  bk_s1;
	logic           rv_s1;
	logic [SW-1:0]  rem_id_q;
	logic           found_q;
	logic [BW-1:0]  best_q;
	logic [31:0]    best_st_q;

	// least/most loaded scan
	logic           scan_run_q;
	logic [SW-1:0]  sk_q;
	logic           have_q;
	logic [SW-1:0]  lo_q, hi_q;
	logic [LW-1:0]  lo_ld_q, hi_ld_q;

	// result register
	logic        out_valid_q;
	logic [47:0] out_q;

	// bucket memory {prev+1, server, stamp}
	logic [MW-1:0] mem [MAX_BUCKETS];
	logic [MW-1:0] rd_q;
	logic          wen;
	logic [BW-1:0] wadr;
	logic [MW-1:0] wdat;
	logic [BW-1:0] radr;

	logic [CW-1:0]  nb;
	logic [SCW-1:0] tt;
	logic [SCW-1:0] nn;
	logic           div_start;
	logic [31:0]    div_dividend;
	logic [DVW-1:0] div_divisor;
	logic           div_done;
	logic [31:0]    div_quot;
	logic [DVW-1:0] div_rem;

	logic [SW-1:0]  rd_srv;
	logic [SW:0]    rd_prev;
	logic [31:0]    rd_st;
	logic [SW:0]    rd_pm1;
	logic [LW-1:0]  lo_inc;

	function automatic logic [SW-1:0] qidx(input logic [SW-1:0] h, input logic [SCW-1:0] c);
		logic [SCW:0] s;
		s = (SCW+1)'(h) + (SCW+1)'(c);
		if (s >= (SCW+1)'(MAX_SERVERS)) s = s - (SCW+1)'(MAX_SERVERS);
		return s[SW-1:0];
	endfunction

	// effective configuration
	always_comb begin
		if (bc_q == '0) nb = CW'(1);
		else if (32'(bc_q) > 32'(MAX_BUCKETS)) nb = CW'(MAX_BUCKETS);
		else nb = CW'(bc_q);
		if (ts_q == '0) tt = SCW'(1);
		else if (32'(ts_q) > 32'(MAX_SERVERS)) tt = SCW'(MAX_SERVERS);
		else tt = SCW'(ts_q);
		if (ia_q == '0 || 32'(ia_q) > 32'(tt)) nn = tt;
		else nn = SCW'(ia_q);
	end

	// shared divider: hash mod buckets, or buckets per active server
	assign div_start    = (cmd.op == blb_pkg::OP_DIV_MOD) || (cmd.op == blb_pkg::OP_DIV_FAC);
	assign div_dividend = (cmd.op == blb_pkg::OP_DIV_FAC) ? 32'(nb) : hash_q;
	assign div_divisor  = (cmd.op == blb_pkg::OP_DIV_FAC) ? DVW'(nn) : DVW'(nb);

	blb_div #(.DVW(DVW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign rd_srv  = rd_q[32 +: SW];
	assign rd_prev = rd_q[32+SW +: SW+1];
	assign rd_st   = rd_q[31:0];
	assign rd_pm1  = rd_prev - (SW+1)'(1);
	assign lo_inc  = (lo_ld_q < LOAD_LIM) ? lo_ld_q + LW'(1) : lo_ld_q;

	// memory port control
	always_comb begin
		wen  = 1'b0;
		wadr = bk_q[BW-1:0];
		wdat = {(SW+1)'(0), lo_q, now_q};
		radr = bk_q[BW-1:0];
		unique case (cmd.op)
			blb_pkg::OP_INIT_DIRECT: begin
				wen  = 1'b1;
				wdat = {(SW+1)'(0), grp_q[SW-1:0], now_q};
			end
			blb_pkg::OP_INIT_LEFT: wen = 1'b1;
			blb_pkg::OP_REM_MOVE: begin
				wen  = 1'b1;
				wdat = {(SW+1)'(rem_id_q) + (SW+1)'(1), lo_q, now_q};
			end
			blb_pkg::OP_REB_MOVE: begin
				wen  = 1'b1;
				wadr = best_q;
				wdat = {(SW+1)'(hi_q) + (SW+1)'(1), lo_q, now_q};
			end
			blb_pkg::OP_LK_READ: radr = div_rem[BW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wen) mem[wadr] <= wdat;
		rd_q <= mem[radr];
	end

	// status to controller; a waiting result holds off the next item
	always_comb begin
		stat.cmd         = cmd_q;
		stat.out_free    = !out_valid_q;
		stat.div_done    = div_done;
		stat.scan_done   = !scan_run_q;
		stat.bk_end      = bk_q == nb;
		stat.init_direct = (fac_q != '0) && (grp_q < nn);
		stat.add_ok      = (scnt_q != '0) && (acnt_q < SCW'(MAX_SERVERS));
		stat.rem_ok      = (acnt_q > SCW'(1)) && (scnt_q < SCW'(MAX_SERVERS));
		stat.reb_go      = (acnt_q >= SCW'(2))
			&& ((LW+1)'(lo_ld_q) + (LW+1)'(1) < (LW+1)'(hi_ld_q));
		stat.reb_done    = (bk_q == nb) && !rv_s1;
		stat.found       = found_q;
		stat.match       = rd_srv == rem_id_q;
	end

	// control state of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q        <= blb_pkg::BC_RESET;
			ts_q        <= blb_pkg::TS_RESET;
			ia_q        <= blb_pkg::IA_RESET;
			acnt_q      <= '0;
			scnt_q      <= '0;
			ahead_q     <= '0;
			shead_q     <= '0;
			scan_run_q  <= 1'b0;
			rv_s1       <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < MAX_SERVERS; k++) begin
				load_q[k] <= '0;
				act_q[k]  <= 1'b0;
			end
		end else begin
			// configuration writes
			if (cfg_wr_en) begin
				unique case (cfg_addr)
					blb_pkg::REG_BUCKET_COUNT:   bc_q <= cfg_wdata;
					blb_pkg::REG_TOTAL_SERVERS:  ts_q <= cfg_wdata[4:0];
					blb_pkg::REG_INITIAL_ACTIVE: ia_q <= cfg_wdata[4:0];
					default: ;
				endcase
			end

			// result valid: set on finish, cleared when taken
			if (cmd.op == blb_pkg::OP_LK_FIN || cmd.op == blb_pkg::OP_FIN) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;

			// server scan, one server a cycle
			if (scan_run_q) begin
				if (act_q[sk_q]) begin
					if (!have_q || load_q[sk_q] < lo_ld_q) begin
						lo_q    <= sk_q;
						lo_ld_q <= load_q[sk_q];
					end
					if (!have_q || load_q[sk_q] > hi_ld_q) begin
						hi_q    <= sk_q;
						hi_ld_q <= load_q[sk_q];
					end
					have_q <= 1'b1;
				end
				if (sk_q == SW'(MAX_SERVERS - 1)) scan_run_q <= 1'b0;
				else sk_q <= sk_q + SW'(1);
			end

			unique case (cmd.op)
				blb_pkg::OP_CAPTURE: begin
					cmd_q  <= s_axis_tuser;
					hash_q <= s_axis_tdata[31:0];
					now_q  <= s_axis_tdata[63:32];
				end
				blb_pkg::OP_LK_FIN: begin
					out_q <= {5'(acnt_q), rd_st, (rd_prev != '0),
						(rd_prev != '0) ? 4'(rd_pm1) : 4'd0, 4'(rd_srv), blb_pkg::ST_OK};
				end
				blb_pkg::OP_FIN: begin
					out_q <= {5'(acnt_q), 32'd0, 1'b0, 4'd0, 4'd0, cmd.status};
				end
				blb_pkg::OP_INIT_SET: begin
					fac_q    <= div_quot[CW-1:0];
					grp_q    <= '0;
					within_q <= '0;
					bk_q     <= '0;
					acnt_q   <= nn;
					scnt_q   <= tt - nn;
					ahead_q  <= '0;
					shead_q  <= '0;
					for (int k = 0; k < MAX_SERVERS; k++) begin
						act_q[k]  <= 32'(k) < 32'(nn);
						load_q[k] <= (32'(k) < 32'(nn)) ? LW'(div_quot[CW-1:0]) : '0;
						actq_q[k] <= SW'(k);
						spq_q[k]  <= SW'(k + int'(nn));
					end
				end
				blb_pkg::OP_INIT_DIRECT: begin
					bk_q <= bk_q + CW'(1);
					if (within_q + CW'(1) == fac_q) begin
						within_q <= '0;
						grp_q    <= grp_q + SCW'(1);
					end else begin
						within_q <= within_q + CW'(1);
					end
				end
				blb_pkg::OP_INIT_LEFT, blb_pkg::OP_REM_MOVE: begin
					load_q[lo_q] <= lo_inc;
					bk_q         <= bk_q + CW'(1);
				end
				blb_pkg::OP_SCAN_START: begin
					scan_run_q <= 1'b1;
					sk_q       <= '0;
					have_q     <= 1'b0;
				end
				blb_pkg::OP_ADD_POP: begin
					shead_q                       <= qidx(shead_q, SCW'(1));
					scnt_q                        <= scnt_q - SCW'(1);
					actq_q[qidx(ahead_q, acnt_q)] <= spq_q[shead_q];
					acnt_q                        <= acnt_q + SCW'(1);
					load_q[spq_q[shead_q]]        <= '0;
					act_q[spq_q[shead_q]]         <= 1'b1;
				end
				blb_pkg::OP_REM_POP: begin
					ahead_q                      <= qidx(ahead_q, SCW'(1));
					acnt_q                       <= acnt_q - SCW'(1);
					spq_q[qidx(shead_q, scnt_q)] <= actq_q[ahead_q];
					scnt_q                       <= scnt_q + SCW'(1);
					load_q[actq_q[ahead_q]]      <= '0;
					act_q[actq_q[ahead_q]]       <= 1'b0;
					rem_id_q                     <= actq_q[ahead_q];
					bk_q                         <= '0;
				end
				blb_pkg::OP_BK_START: begin
					bk_q    <= '0;
					found_q <= 1'b0;
					rv_s1   <= 1'b0;
				end
				blb_pkg::OP_BK_NEXT: bk_q <= bk_q + CW'(1);
				blb_pkg::OP_REB_SCAN: begin
					// issue the next read, compare the previous one
					if (bk_q != nb) begin
						bk_q  <= bk_q + CW'(1);
						bk_s1 <= bk_q[BW-1:0];
						rv_s1 <= 1'b1;
					end else begin
						rv_s1 <= 1'b0;
					end
					if (rv_s1 && rd_srv == hi_q && (!found_q || rd_st < best_st_q)) begin
						found_q   <= 1'b1;
						best_q    <= bk_s1;
						best_st_q <= rd_st;
					end
				end
				blb_pkg::OP_REB_MOVE: begin
					load_q[lo_q] <= lo_inc;
					load_q[hi_q] <= hi_ld_q - LW'(1);
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

@@ hdl/blb_ctrl.sv @@
`timescale 1ns / 1ps

module blb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  blb_pkg::stat_t stat,
	output blb_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_WDIV_L = 4'd2;
	localparam logic [3:0] S_LREAD  = 4'd3;
	localparam logic [3:0] S_LLATCH = 4'd4;
	localparam logic [3:0] S_WDIV_I = 4'd5;
	localparam logic [3:0] S_IBK    = 4'd6;
	localparam logic [3:0] S_IPICK  = 4'd7;
	localparam logic [3:0] S_RSTART = 4'd8;
	localparam logic [3:0] S_RSCAN  = 4'd9;
	localparam logic [3:0] S_RBK    = 4'd10;
	localparam logic [3:0] S_MREAD  = 4'd11;
	localparam logic [3:0] S_MCHK   = 4'd12;
	localparam logic [3:0] S_MPICK  = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// sequencer
	always_comb begin
		state_d       = state_q;
		cmd.op        = blb_pkg::OP_NONE;
		cmd.status    = blb_pkg::ST_OK;
		s_axis_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = stat.out_free;
				if (s_axis_tvalid && stat.out_free) begin
					cmd.op  = blb_pkg::OP_CAPTURE;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (stat.cmd)
					blb_pkg::CMD_LOOKUP: begin
						cmd.op  = blb_pkg::OP_DIV_MOD;
						state_d = S_WDIV_L;
					end
					blb_pkg::CMD_INIT: begin
						cmd.op  = blb_pkg::OP_DIV_FAC;
						state_d = S_WDIV_I;
					end
					blb_pkg::CMD_ADD: begin
						if (stat.add_ok) begin
							cmd.op  = blb_pkg::OP_ADD_POP;
							state_d = S_RSTART;
						end else begin
							cmd.op     = blb_pkg::OP_FIN;
							cmd.status = blb_pkg::ST_NO_SPARE;
							state_d    = S_IDLE;
						end
					end
					default: begin
						if (stat.rem_ok) begin
							cmd.op  = blb_pkg::OP_REM_POP;
							state_d = S_MREAD;
						end else begin
							cmd.op     = blb_pkg::OP_FIN;
							cmd.status = blb_pkg::ST_LAST_SERVER;
							state_d    = S_IDLE;
						end
					end
				endcase
			end
			S_WDIV_L: if (stat.div_done) state_d = S_LREAD;
			S_LREAD: begin
				cmd.op  = blb_pkg::OP_LK_READ;
				state_d = S_LLATCH;
			end
			S_LLATCH: begin
				cmd.op  = blb_pkg::OP_LK_FIN;
				state_d = S_IDLE;
			end
			S_WDIV_I: begin
				if (stat.div_done) begin
					cmd.op  = blb_pkg::OP_INIT_SET;
					state_d = S_IBK;
				end
			end
			// initialize walk: contiguous runs, leftovers to the least loaded
			S_IBK: begin
				priority if (stat.bk_end) begin
					cmd.op  = blb_pkg::OP_FIN;
					state_d = S_IDLE;
				end else if (stat.init_direct) begin
					cmd.op = blb_pkg::OP_INIT_DIRECT;
				end else begin
					cmd.op  = blb_pkg::OP_SCAN_START;
					state_d = S_IPICK;
				end
			end
			S_IPICK: begin
				if (stat.scan_done) begin
					cmd.op  = blb_pkg::OP_INIT_LEFT;
					state_d = S_IBK;
				end
			end
			// rebalance loop
			S_RSTART: begin
				cmd.op  = blb_pkg::OP_SCAN_START;
				state_d = S_RSCAN;
			end
			S_RSCAN: begin
				if (stat.scan_done) begin
					if (stat.reb_go) begin
						cmd.op  = blb_pkg::OP_BK_START;
						state_d = S_RBK;
					end else begin
						cmd.op  = blb_pkg::OP_FIN;
						state_d = S_IDLE;
					end
				end
			end
			S_RBK: begin
				priority if (!stat.reb_done) begin
					cmd.op = blb_pkg::OP_REB_SCAN;
				end else if (stat.found) begin
					cmd.op  = blb_pkg::OP_REB_MOVE;
					state_d = S_RSTART;
				end else begin
					cmd.op  = blb_pkg::OP_FIN;
					state_d = S_IDLE;
				end
			end
			// remove walk over the table
			S_MREAD: begin
				if (stat.bk_end) begin
					cmd.op  = blb_pkg::OP_FIN;
					state_d = S_IDLE;
				end else begin
					cmd.op  = blb_pkg::OP_M_RD;
					state_d = S_MCHK;
				end
			end
			S_MCHK: begin
				if (stat.match) begin
					cmd.op  = blb_pkg::OP_SCAN_START;
					state_d = S_MPICK;
				end else begin
					cmd.op  = blb_pkg::OP_BK_NEXT;
					state_d = S_MREAD;
				end
			end
			S_MPICK: begin
				if (stat.scan_done) begin
					cmd.op  = blb_pkg::OP_REM_MOVE;
					state_d = S_MREAD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ hdl/bucket_table_load_balancer_top.sv @@
`timescale 1ns / 1ps

// Channel     Handshake                      Payload
// input item  s_axis_tvalid/s_axis_tready    tuser: command; tdata: flow_hash, now_ticks
// result item m_axis_tvalid/m_axis_tready    tdata: status .. active_count
// config      cfg_wr_en                      cfg_addr, cfg_wdata
//
// Lookup: a 32-step divider forms flow_hash mod buckets, then one registered
// table read. Initialize divides, then maps each bucket directly or, for a leftover
// bucket, after a server scan; remove reads every bucket and scans once per moved
// bucket; add does a scan and table walk per move. Server scans take one server a cycle.
// Reset clears control state only; the table is valid after initialize.
// A result waits in an output register; the next item is taken once it has drained.
module bucket_table_load_balancer_top #(
	parameter int MAX_BUCKETS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [12:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // flow_hash, now_ticks
	input  logic [1:0]  s_axis_tuser,  // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // status, current_server, prev_server,
	                                   // prev_valid, bucket_time, active_count
);

	blb_pkg::cmd_t  cmd;
	blb_pkg::stat_t stat;

	blb_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	blb_dp #(
		.MAX_BUCKETS (MAX_BUCKETS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
